/* src/roulette_curve_lfo_unit_defines.svh */
// assertion macros used by the roulette curve lfo sequencer
`ifndef ROULETTE_CURVE_LFO_UNIT_DEFINES_SVH
`define ROULETTE_CURVE_LFO_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define RCLFO_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("rclfo: assertion failed");
// next-cycle implication
`define RCLFO_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("rclfo: assertion failed");
`else
`define RCLFO_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define RCLFO_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

/* src/rclfo_pkg.sv */
package rclfo_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_W     = 34;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam int PEAK_OUT     = 20480;

    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5
    };

    // integer square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bits;
        n    = n_in;
        res  = 64'd0;
        bits = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (n >= res + bits) begin
                n   = n - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    // q30 value of 2^(2^-j)
    function automatic logic [31:0] exp2_coef(input int j);
        logic [63:0] c;
        c = isqrt64(64'd1 << 61);
        for (int t = 1; t < 10; t++) begin
            if (t < j) begin
                c = isqrt64(c << 30);
            end
        end
        return c[31:0];
    endfunction

    // fraction bit b of the pitch uses coefficient 10-b
    localparam logic [31:0] EXP_COEF [0:9] = '{
        exp2_coef(10), exp2_coef(9), exp2_coef(8), exp2_coef(7), exp2_coef(6),
        exp2_coef(5), exp2_coef(4), exp2_coef(3), exp2_coef(2), exp2_coef(1)
    };

    typedef enum logic [2:0] {
        CFG_FIXED_RADIUS    = 3'd0,
        CFG_ROTATING_RADIUS = 3'd1,
        CFG_DISTANCE        = 3'd2,
        CFG_FREQUENCY       = 3'd3,
        CFG_CURVE_MODE      = 3'd4,
        CFG_DIST_TRACKS     = 3'd5,
        CFG_SAMPLE_RATE     = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [14:0]        fixed_radius_knob;
        logic [13:0]        rotating_radius_knob;
        logic [13:0]        distance_knob;
        logic signed [13:0] frequency_knob;
        logic               curve_mode;
        logic               distance_tracks_radius;
        logic [17:0]        sample_rate_hz;
    } cfg_t;

    typedef enum logic [4:0] {
        S_IDLE, S_EXP, S_INC_START, S_INC_WAIT, S_MUL, S_ANG_START, S_ANG_WAIT,
        S_C1_START, S_C1_WAIT, S_C2_START, S_C2_WAIT, S_MX1, S_MX2, S_MX3, S_MY2,
        S_MY3, S_SX_MUL, S_SX_START, S_SX_WAIT, S_SY_MUL, S_SY_START, S_SY_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_EXP, OP_INC_DONE, OP_MUL, OP_ANG_DONE, OP_C1_DONE,
        OP_C2_DONE, OP_MX1, OP_MX2, OP_MX3, OP_MY2, OP_MY3, OP_SX, OP_SX_DONE,
        OP_SY, OP_SY_DONE, OP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        DIV_INC, DIV_ANG, DIV_SCALE
    } div_sel_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] step;
        logic       div_start;
        div_sel_t   div_sel;
        logic       cordic_start;
        logic       angle_sel;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic cordic_done;
    } status_t;

endpackage

/* src/rclfo_if.sv */
interface rclfo_sample_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] pitch_cv;
    logic signed [14:0] fixed_radius_cv;
    logic signed [14:0] rotating_radius_cv;
    logic signed [14:0] distance_cv;

    modport source (output valid, output pitch_cv, output fixed_radius_cv,
                    output rotating_radius_cv, output distance_cv, input ready);
    modport sink (input valid, input pitch_cv, input fixed_radius_cv,
                  input rotating_radius_cv, input distance_cv, output ready);
endinterface

interface rclfo_point_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;

    modport source (output valid, output x_out, output y_out, input ready);
    modport sink (input valid, input x_out, input y_out, output ready);
endinterface

interface rclfo_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [17:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/roulette_curve_lfo_unit.sv */
// roulette curve lfo: one x/y point per sample transaction
// one sample in flight; the next is accepted only after the last point has been
// loaded into the output register, which waits while a previous point is not taken
// each sample takes four passes through the shared radix-2 divider,
// two cordic passes, a 10-step exp2 and a 15-step shift-add multiply
// rst_n is asynchronous active low: phase to zero, knobs to defaults, no output valid
module roulette_curve_lfo_unit #(
    parameter int PHASE_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input logic         clk,
    input logic         rst_n,
    rclfo_sample_if.sink  sample_in,
    rclfo_point_if.source point_out,
    rclfo_cfg_if.sink     cfg_wr
);
    import rclfo_pkg::*;

    // configuration register file, always ready
    cfg_t    cfg_reg, cfg_next;
    cmd_t    cmd;
    status_t status;

    assign cfg_wr.ready = 1'b1;

    // writes only while the block is idle (user's duty, unchecked); datapath reads these directly
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr.valid) begin
            case (cfg_idx_t'(cfg_wr.index))
                CFG_FIXED_RADIUS:    cfg_next.fixed_radius_knob    = cfg_wr.data[14:0];
                CFG_ROTATING_RADIUS: cfg_next.rotating_radius_knob = cfg_wr.data[13:0];
                CFG_DISTANCE:        cfg_next.distance_knob        = cfg_wr.data[13:0];
                CFG_FREQUENCY:       cfg_next.frequency_knob       = cfg_wr.data[13:0];
                CFG_CURVE_MODE:      cfg_next.curve_mode           = cfg_wr.data[0];
                CFG_DIST_TRACKS:     cfg_next.distance_tracks_radius = cfg_wr.data[0];
                CFG_SAMPLE_RATE:     cfg_next.sample_rate_hz       = cfg_wr.data[17:0];
                default: begin
                    // unused index: ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.fixed_radius_knob      <= 15'd5120;
            cfg_reg.rotating_radius_knob   <= 14'd3072;
            cfg_reg.distance_knob          <= 14'd5120;
            cfg_reg.frequency_knob         <= '0;
            cfg_reg.curve_mode             <= 1'b0;
            cfg_reg.distance_tracks_radius <= 1'b0;
            cfg_reg.sample_rate_hz         <= 18'd44100;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer: walks exp2, increment divide, angle multiply/divide, cordic, x/y products, scaling
    rclfo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .out_valid (point_out.valid),
        .out_ready (point_out.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath: phase accumulator, shared divider and cordic, output register
    // the output register lets the next sample transaction start while a point waits
    rclfo_dp #(
        .PHASE_BITS (PHASE_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg                (cfg_reg),
        .pitch_cv           (sample_in.pitch_cv),
        .fixed_radius_cv    (sample_in.fixed_radius_cv),
        .rotating_radius_cv (sample_in.rotating_radius_cv),
        .distance_cv        (sample_in.distance_cv),
        .x_out              (point_out.x_out),
        .y_out              (point_out.y_out)
    );

endmodule

/* src/rclfo_div.sv */
module rclfo_div #(
    parameter int NW  = 47,
    parameter int DVW = 18
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [NW-1:0]  num,
    input  logic [DVW-1:0] den,
    output logic [NW-1:0]  quo,
    output logic           done
);
    import rclfo_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [NW-1:0]  quo_reg, quo_next;
    logic [DVW-1:0] den_reg, den_next;
    logic [DVW:0]   rem_sh;
    logic [DVW:0]   diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh    = {rem_reg, quo_reg[NW-1]};
        diff      = rem_sh - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = diff[DVW] ? rem_sh[DVW-1:0] : diff[DVW-1:0];
            quo_next = {quo_reg[NW-2:0], ~diff[DVW]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

/* src/rclfo_cordic.sv */
module rclfo_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [ANGLE_BITS-1:0]                  angle,
    output logic signed [rclfo_pkg::CORDIC_W-1:0]  cos_val,
    output logic signed [rclfo_pkg::CORDIC_W-1:0]  sin_val,
    output logic                                   done
);
    import rclfo_pkg::*;

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [4:0]                 step_reg, step_next;
    logic                       neg_reg, neg_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [CORDIC_W-1:0] z_reg, z_next;
    logic [31:0]                u;
    logic [31:0]                uf;
    logic                       fold;
    logic signed [CORDIC_W-1:0] dx, dy, at;

    always_comb begin
        u    = 32'(angle) << (32 - ANGLE_BITS);
        // left half-plane: rotate by half a turn, negate at the end
        fold = u[31] ^ u[30];
        uf   = fold ? {~u[31], u[30:0]} : u;
        dx   = y_reg >>> step_reg;
        dy   = x_reg >>> step_reg;
        at   = $signed({2'b00, ATAN_TURNS[step_reg]});

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = fold;
            x_next    = $signed({2'b00, CORDIC_GAIN_Q30});
            y_next    = '0;
            z_next    = $signed({{2{uf[31]}}, uf});
        end else if (busy_reg) begin
            if (!z_reg[CORDIC_W-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == 5'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk) begin
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    assign cos_val = neg_reg ? -x_reg : x_reg;
    assign sin_val = neg_reg ? -y_reg : y_reg;
    assign done    = done_reg;

endmodule

/* src/rclfo_dp.sv */
module rclfo_dp #(
    parameter int PHASE_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rclfo_pkg::cmd_t        cmd,
    output rclfo_pkg::status_t     status,
    input  rclfo_pkg::cfg_t        cfg,
    input  logic signed [14:0]     pitch_cv,
    input  logic signed [14:0]     fixed_radius_cv,
    input  logic signed [14:0]     rotating_radius_cv,
    input  logic signed [14:0]     distance_cv,
    output logic signed [15:0]     x_out,
    output logic signed [15:0]     y_out
);
    import rclfo_pkg::*;

    localparam int DW  = PHASE_BITS + 15;
    localparam int DVW = 18;
    localparam int XW  = 16 + CORDIC_W;
    localparam int SW  = XW + 16;

    logic [PHASE_BITS-1:0]      phase_reg, phase_next;
    logic [9:0]                 f_reg, f_next;
    logic [6:0]                 pi_reg, pi_next;
    logic [30:0]                m_reg, m_next;
    logic [13:0]                r_reg, r_next;
    logic [14:0]                d_reg, d_next;
    logic [14:0]                k_reg, k_next;
    logic [DW-1:0]              prod_reg, prod_next;
    logic [ANGLE_BITS-1:0]      a2_reg, a2_next;
    logic signed [CORDIC_W-1:0] c1_reg, c1_next, s1_reg, s1_next;
    logic signed [CORDIC_W-1:0] c2_reg, c2_next, s2_reg, s2_next;
    logic signed [XW-1:0]       t1_reg, t1_next, t2_reg, t2_next;
    logic signed [XW-1:0]       xs_reg, xs_next, ys_reg, ys_next;
    logic [DW-1:0]              snum_reg, snum_next;
    logic                       sneg_reg, sneg_next;
    logic signed [15:0]         xr_reg, xr_next, yr_reg, yr_next;
    logic signed [15:0]         xo_reg, xo_next, yo_reg, yo_next;

    // load-time arithmetic
    logic signed [15:0] p_sum;
    logic [16:0]        poff;
    logic signed [16:0] r_raw, big_r_raw, d_raw, r_cl, big_r_cl, d_cl;
    logic [14:0]        d_sel;

    // exp2, increment, multiplier, scaling
    logic [62:0]                exp_prod;
    logic [62:0]                exp_rnd;
    logic [7:0]                 inc_sh;
    logic [7:0]                 inc_nsh;
    logic [DW-1:0]              m_ext;
    logic [DW-1:0]              inc_num;
    logic [PHASE_BITS-1:0]      inc_val;
    logic [15:0]                s_sum;
    logic [14:0]                mul_a;
    logic signed [CORDIC_W-1:0] mul_b;
    logic signed [XW-1:0]       mul_p;
    logic signed [XW-1:0]       sc_src;
    logic [XW-1:0]              sc_mag;
    logic [SW-1:0]              sc_full;
    logic [15:0]                q16;
    logic signed [15:0]         q_signed;

    logic [DW-1:0]              div_num;
    logic [DVW-1:0]             div_den;
    logic [DW-1:0]              div_quo;
    logic                       div_done;
    logic [ANGLE_BITS-1:0]      cordic_ang;
    logic signed [CORDIC_W-1:0] cordic_cos, cordic_sin;
    logic                       cordic_done;

    always_comb begin
        p_sum = {{2{cfg.frequency_knob[13]}}, cfg.frequency_knob} + {pitch_cv[14], pitch_cv};
        if (p_sum > 16'sd8192) begin
            p_sum = 16'sd8192;
        end
        poff = {p_sum[15], p_sum} + 17'h08000;

        r_raw     = $signed({3'b000, cfg.rotating_radius_knob}) + 17'(rotating_radius_cv);
        big_r_raw = $signed({2'b00, cfg.fixed_radius_knob}) + 17'(fixed_radius_cv);
        d_raw     = $signed({3'b000, cfg.distance_knob}) + 17'(distance_cv);

        r_cl = r_raw;
        if (r_cl < 17'sd1024) r_cl = 17'sd1024;
        if (r_cl > 17'sd10240) r_cl = 17'sd10240;

        big_r_cl = big_r_raw;
        d_cl     = d_raw;
        if (!cfg.curve_mode) begin
            if (big_r_cl < r_cl) big_r_cl = r_cl;
            if (big_r_cl > 17'sd20480) big_r_cl = 17'sd20480;
            if (d_cl < 17'sd1024) d_cl = 17'sd1024;
            if (d_cl > 17'sd10240) d_cl = 17'sd10240;
        end else begin
            if (big_r_cl < 17'sd1024) big_r_cl = 17'sd1024;
            if (big_r_cl > 17'sd20480) big_r_cl = 17'sd20480;
            if (d_cl < 17'sd1024) d_cl = 17'sd1024;
            if (d_cl > 17'sd20480) d_cl = 17'sd20480;
        end
        d_sel = cfg.distance_tracks_radius ? {1'b0, r_cl[13:0]} : d_cl[14:0];
    end

    always_comb begin
        exp_prod = 63'(m_reg) * 63'(EXP_COEF[cmd.step]);
        exp_rnd  = exp_prod + 63'h2000_0000;

        // pitch integer part shifts the mantissa into phase units
        inc_sh  = {1'b0, pi_reg} + 8'(PHASE_BITS - 62);
        inc_nsh = -inc_sh;
        m_ext   = DW'(m_reg);
        inc_num = inc_sh[7] ? (m_ext >> inc_nsh) : (m_ext << inc_sh);
        if (div_quo > (DW'(1) << (PHASE_BITS - 1))) begin
            inc_val = PHASE_BITS'(1) << (PHASE_BITS - 1);
        end else begin
            inc_val = div_quo[PHASE_BITS-1:0];
        end

        s_sum = {1'b0, k_reg} + {1'b0, d_reg};

        case (cmd.op)
            OP_MX1:  begin mul_a = k_reg; mul_b = c1_reg; end
            OP_MX2:  begin mul_a = d_reg; mul_b = c2_reg; end
            OP_MX3:  begin mul_a = k_reg; mul_b = s1_reg; end
            OP_MY2:  begin mul_a = d_reg; mul_b = s2_reg; end
            default: begin mul_a = k_reg; mul_b = c1_reg; end
        endcase
        mul_p = $signed({1'b0, mul_a}) * mul_b;

        // |v| * 20480 + half the divisor, then drop the q30 scale
        sc_src  = (cmd.op == OP_SY) ? ys_reg : xs_reg;
        sc_mag  = sc_src[XW-1] ? XW'(-sc_src) : XW'(sc_src);
        sc_full = (SW'(sc_mag) << 14) + (SW'(sc_mag) << 12) + (SW'(s_sum) << 29);

        q16      = (div_quo > DW'(PEAK_OUT)) ? 16'(PEAK_OUT) : div_quo[15:0];
        q_signed = sneg_reg ? -$signed(q16) : $signed(q16);
    end

    always_comb begin
        case (cmd.div_sel)
            DIV_INC: begin
                div_num = inc_num;
                div_den = (cfg.sample_rate_hz == '0) ? 18'd1 : cfg.sample_rate_hz;
            end
            DIV_ANG: begin
                div_num = prod_reg;
                div_den = DVW'(r_reg);
            end
            DIV_SCALE: begin
                div_num = snum_reg;
                div_den = DVW'(s_sum);
            end
            default: begin
                div_num = snum_reg;
                div_den = DVW'(s_sum);
            end
        endcase
        cordic_ang = cmd.angle_sel ? a2_reg : phase_reg[PHASE_BITS-1 -: ANGLE_BITS];
    end

    always_comb begin
        phase_next = phase_reg;
        f_next     = f_reg;
        pi_next    = pi_reg;
        m_next     = m_reg;
        r_next     = r_reg;
        d_next     = d_reg;
        k_next     = k_reg;
        prod_next  = prod_reg;
        a2_next    = a2_reg;
        c1_next    = c1_reg;
        s1_next    = s1_reg;
        c2_next    = c2_reg;
        s2_next    = s2_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        xs_next    = xs_reg;
        ys_next    = ys_reg;
        snum_next  = snum_reg;
        sneg_next  = sneg_reg;
        xr_next    = xr_reg;
        yr_next    = yr_reg;
        xo_next    = xo_reg;
        yo_next    = yo_reg;
        case (cmd.op)
            OP_LOAD: begin
                f_next  = poff[9:0];
                pi_next = poff[16:10];
                m_next  = 31'h4000_0000;
                r_next  = r_cl[13:0];
                d_next  = d_sel;
                k_next  = cfg.curve_mode ? (big_r_cl[14:0] + {1'b0, r_cl[13:0]})
                                         : (big_r_cl[14:0] - {1'b0, r_cl[13:0]});
            end
            OP_EXP: begin
                if (f_reg[cmd.step]) begin
                    m_next = exp_rnd[60:30];
                end
            end
            OP_INC_DONE: begin
                phase_next = phase_reg + inc_val;
                prod_next  = '0;
            end
            OP_MUL: begin
                if (k_reg[cmd.step]) begin
                    prod_next = prod_reg + (DW'(phase_reg) << cmd.step);
                end
            end
            OP_ANG_DONE: a2_next = div_quo[PHASE_BITS-1 -: ANGLE_BITS];
            OP_C1_DONE: begin
                c1_next = cordic_cos;
                s1_next = cordic_sin;
            end
            OP_C2_DONE: begin
                c2_next = cordic_cos;
                s2_next = cordic_sin;
            end
            OP_MX1: t1_next = mul_p;
            OP_MX2: t2_next = mul_p;
            OP_MX3: begin
                xs_next = cfg.curve_mode ? (t1_reg - t2_reg) : (t1_reg + t2_reg);
                t1_next = mul_p;
            end
            OP_MY2: t2_next = mul_p;
            OP_MY3: ys_next = t1_reg - t2_reg;
            OP_SX, OP_SY: begin
                snum_next = DW'(sc_full[SW-1:30]);
                sneg_next = sc_src[XW-1];
            end
            OP_SX_DONE: xr_next = q_signed;
            OP_SY_DONE: yr_next = q_signed;
            OP_OUT: begin
                xo_next = xr_reg;
                yo_next = yr_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk) begin
        f_reg    <= f_next;
        pi_reg   <= pi_next;
        m_reg    <= m_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        k_reg    <= k_next;
        prod_reg <= prod_next;
        a2_reg   <= a2_next;
        c1_reg   <= c1_next;
        s1_reg   <= s1_next;
        c2_reg   <= c2_next;
        s2_reg   <= s2_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        xs_reg   <= xs_next;
        ys_reg   <= ys_next;
        snum_reg <= snum_next;
        sneg_reg <= sneg_next;
        xr_reg   <= xr_next;
        yr_reg   <= yr_next;
        xo_reg   <= xo_next;
        yo_reg   <= yo_next;
    end

    rclfo_div #(
        .NW  (DW),
        .DVW (DVW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    rclfo_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.cordic_start),
        .angle   (cordic_ang),
        .cos_val (cordic_cos),
        .sin_val (cordic_sin),
        .done    (cordic_done)
    );

    assign status.div_done    = div_done;
    assign status.cordic_done = cordic_done;
    assign x_out = xo_reg;
    assign y_out = yo_reg;

endmodule

/* src/rclfo_ctrl.sv */
`include "roulette_curve_lfo_unit_defines.svh"

module rclfo_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output rclfo_pkg::cmd_t     cmd,
    input  rclfo_pkg::status_t  status
);
    import rclfo_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_EXP;
                    step_next  = '0;
                end
            end
            S_EXP: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd9) begin
                    state_next = S_INC_START;
                end
            end
            S_INC_START: state_next = S_INC_WAIT;
            S_INC_WAIT: begin
                if (status.div_done) begin
                    state_next = S_MUL;
                    step_next  = '0;
                end
            end
            S_MUL: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd14) begin
                    state_next = S_ANG_START;
                end
            end
            S_ANG_START: state_next = S_ANG_WAIT;
            S_ANG_WAIT:  if (status.div_done) state_next = S_C1_START;
            S_C1_START:  state_next = S_C1_WAIT;
            S_C1_WAIT:   if (status.cordic_done) state_next = S_C2_START;
            S_C2_START:  state_next = S_C2_WAIT;
            S_C2_WAIT:   if (status.cordic_done) state_next = S_MX1;
            S_MX1:       state_next = S_MX2;
            S_MX2:       state_next = S_MX3;
            S_MX3:       state_next = S_MY2;
            S_MY2:       state_next = S_MY3;
            S_MY3:       state_next = S_SX_MUL;
            S_SX_MUL:    state_next = S_SX_START;
            S_SX_START:  state_next = S_SX_WAIT;
            S_SX_WAIT:   if (status.div_done) state_next = S_SY_MUL;
            S_SY_MUL:    state_next = S_SY_START;
            S_SY_START:  state_next = S_SY_WAIT;
            S_SY_WAIT:   if (status.div_done) state_next = S_DONE;
            S_DONE:      if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.op           = OP_NONE;
        cmd.step         = step_reg;
        cmd.div_start    = 1'b0;
        cmd.div_sel      = DIV_INC;
        cmd.cordic_start = 1'b0;
        cmd.angle_sel    = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:      if (in_valid) cmd.op = OP_LOAD;
            S_EXP:       cmd.op = OP_EXP;
            S_INC_START: cmd.div_start = 1'b1;
            S_INC_WAIT:  if (status.div_done) cmd.op = OP_INC_DONE;
            S_MUL:       cmd.op = OP_MUL;
            S_ANG_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_ANG;
            end
            S_ANG_WAIT: begin
                cmd.div_sel = DIV_ANG;
                if (status.div_done) cmd.op = OP_ANG_DONE;
            end
            S_C1_START:  cmd.cordic_start = 1'b1;
            S_C1_WAIT:   if (status.cordic_done) cmd.op = OP_C1_DONE;
            S_C2_START: begin
                cmd.cordic_start = 1'b1;
                cmd.angle_sel    = 1'b1;
            end
            S_C2_WAIT:   if (status.cordic_done) cmd.op = OP_C2_DONE;
            S_MX1:       cmd.op = OP_MX1;
            S_MX2:       cmd.op = OP_MX2;
            S_MX3:       cmd.op = OP_MX3;
            S_MY2:       cmd.op = OP_MY2;
            S_MY3:       cmd.op = OP_MY3;
            S_SX_MUL:    cmd.op = OP_SX;
            S_SX_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SCALE;
            end
            S_SX_WAIT: begin
                cmd.div_sel = DIV_SCALE;
                if (status.div_done) cmd.op = OP_SX_DONE;
            end
            S_SY_MUL:    cmd.op = OP_SY;
            S_SY_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SCALE;
            end
            S_SY_WAIT: begin
                cmd.div_sel = DIV_SCALE;
                if (status.div_done) cmd.op = OP_SY_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `RCLFO_ASSERT_NEXT(a_div_no_early_done, clk, rst_n, cmd.div_start, !status.div_done)
    `RCLFO_ASSERT_NEXT(a_cordic_no_early_done, clk, rst_n, cmd.cordic_start, !status.cordic_done)
    `RCLFO_ASSERT_IMPL(a_out_from_load, clk, rst_n, $rose(out_valid_reg), $past(cmd.op == OP_OUT))

endmodule

/* sim/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rclfo_pkg::*;

    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;
    localparam int         CYCLE_LIMIT    = 2_000_000;
    localparam int         DRAIN_CYCLES   = 320;

    logic clk;
    logic rst_n;

    rclfo_sample_if sample_ch ();
    rclfo_point_if  point_ch ();
    rclfo_cfg_if    cfg_ch ();

    roulette_curve_lfo_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_ch.sink),
        .point_out (point_ch.source),
        .cfg_wr    (cfg_ch.sink)
    );

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } point_t;

    // shadow of the block: registers and phase
    cfg_t        knobs;
    logic [31:0] phase_acc;
    logic [63:0] exp_coef [1:10];
    longint      atan_step [0:27] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
        5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    point_t      pending_points [$];
    int          errors;
    int          samples_sent;
    int          points_seen;
    int          cycle_count;
    int          out_stall;
    int          out_hold;
    bit          ready_steady;
    bit          gaps_on;

    // clock and run limit
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d points pending", cycle_count,
                     pending_points.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] root;
        logic [63:0] probe;
        n     = n_in;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v;
    endfunction

    // q30 cosine/sine of a 16-bit angle, folded to the right half plane
    task automatic cordic_sincos(input logic [15:0] ang, output longint c, output longint s);
        logic [31:0] u;
        bit          flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        u    = {ang, 16'h0000};
        flip = 0;
        x    = 652032874;
        y    = 0;
        if (u >= 32'h4000_0000 && u < 32'hC000_0000)
        begin
            u    = u - 32'h8000_0000;
            flip = 1;
        end
        z = longint'($signed(u));
        for (int i = 0; i < 28; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // sum * 2^30 is full scale; round half away from zero, saturate at peak
    function automatic logic signed [15:0] scale_volts(input longint num, input longint sum);
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] q;
        den = 64'(sum) << 30;
        mag = 64'(num < 0 ? -num : num) * 64'd20480;
        q   = (mag + den / 2) / den;
        if (q > 20480)
            q = 20480;
        return num < 0 ? -16'(q) : 16'(q);
    endfunction

    // advance the phase and work out the next curve point
    task automatic predict_point(input logic signed [14:0] pc, input logic signed [14:0] fc,
                                 input logic signed [14:0] rc, input logic signed [14:0] dc);
        longint      pitch;
        longint      poff;
        longint      ip;
        longint      e;
        longint      big_r;
        longint      small_r;
        longint      pen_dist;
        longint      k;
        longint      c1;
        longint      s1;
        longint      c2;
        longint      s2;
        longint      xs;
        longint      ys;
        logic [63:0] mant;
        logic [63:0] rate;
        logic [63:0] inc;
        logic [63:0] prod;
        point_t      pt;
        rate  = knobs.sample_rate_hz == 0 ? 64'd1 : 64'(knobs.sample_rate_hz);
        pitch = longint'(knobs.frequency_knob) + longint'(pc);
        if (pitch > 8192)
            pitch = 8192;
        poff = pitch + 32768;
        ip   = (poff >> 10) - 32;
        mant = 64'd1 << 30;
        for (int b = 0; b < 10; b++)
            if (poff[b])
                mant = (mant * exp_coef[10 - b] + (64'd1 << 29)) >> 30;
        e = 2 + ip;
        if (e >= 0)
            inc = (mant << e) / rate;
        else
            inc = (mant / rate) >> (-e);
        if (inc > 64'h8000_0000)
            inc = 64'h8000_0000;
        phase_acc = phase_acc + inc[31:0];

        big_r    = longint'(knobs.fixed_radius_knob) + longint'(fc);
        small_r  = clip(longint'(knobs.rotating_radius_knob) + longint'(rc), 1024, 10240);
        pen_dist = longint'(knobs.distance_knob) + longint'(dc);
        if (!knobs.curve_mode)
        begin
            big_r    = clip(big_r, small_r, 20480);
            pen_dist = clip(pen_dist, 1024, 10240);
        end
        else
        begin
            big_r    = clip(big_r, 1024, 20480);
            pen_dist = clip(pen_dist, 1024, 20480);
        end
        if (knobs.distance_tracks_radius)
            pen_dist = small_r;
        k = knobs.curve_mode ? big_r + small_r : big_r - small_r;

        prod = (64'(k) * 64'(phase_acc)) / 64'(small_r);
        cordic_sincos(phase_acc[31:16], c1, s1);
        cordic_sincos(prod[31:16], c2, s2);
        xs = knobs.curve_mode ? k * c1 - pen_dist * c2 : k * c1 + pen_dist * c2;
        ys = k * s1 - pen_dist * s2;
        pt.x = scale_volts(xs, k + pen_dist);
        pt.y = scale_volts(ys, k + pen_dist);
        pending_points.push_back(pt);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // receive side: compare each point transaction with the oldest prediction
    always @(negedge clk)
    begin
        point_t want;
        if (rst_n && point_ch.valid && point_ch.ready)
        begin
            points_seen++;
            if (pending_points.size() == 0)
            begin
                errors++;
                $display("[%0t] point with nothing predicted", $realtime);
            end
            else
            begin
                want = pending_points.pop_front();
                if (point_ch.x_out !== want.x)
                    report_mismatch("x_out", point_ch.x_out, want.x);
                if (point_ch.y_out !== want.y)
                    report_mismatch("y_out", point_ch.y_out, want.y);
            end
            out_stall = ready_steady ? 0 : $urandom_range(0, 7);
        end
    end

    // ready drops for the drawn stall, and for the whole of any long hold
    always @(posedge clk)
    begin
        if (out_stall > 0)
            out_stall--;
        point_ch.ready <= rst_n && out_stall == 0 && out_hold == 0;
    end

    // long hold counted down on its own
    always @(posedge clk)
    begin
        if (out_hold > 0)
            out_hold--;
    end

    // one sample transaction, prediction made as it is accepted
    task automatic send_sample(input logic signed [14:0] pc, input logic signed [14:0] fc,
                               input logic signed [14:0] rc, input logic signed [14:0] dc);
        int gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid              <= 1'b1;
        sample_ch.pitch_cv           <= pc;
        sample_ch.fixed_radius_cv    <= fc;
        sample_ch.rotating_radius_cv <= rc;
        sample_ch.distance_cv        <= dc;
        do
            @(negedge clk);
        while (!sample_ch.ready);
        predict_point(pc, fc, rc, dc);
        samples_sent++;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, block idle; valid drops again after each write
    task automatic write_reg(input logic [2:0] idx, input logic [17:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(negedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_FIXED_RADIUS:    knobs.fixed_radius_knob      = value[14:0];
            CFG_ROTATING_RADIUS: knobs.rotating_radius_knob   = value[13:0];
            CFG_DISTANCE:        knobs.distance_knob          = value[13:0];
            CFG_FREQUENCY:       knobs.frequency_knob         = value[13:0];
            CFG_CURVE_MODE:      knobs.curve_mode             = value[0];
            CFG_DIST_TRACKS:     knobs.distance_tracks_radius = value[0];
            CFG_SAMPLE_RATE:     knobs.sample_rate_hz         = value[17:0];
            default:             ;
        endcase
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input int rr_big, input int rr_small, input int dd, input int ff,
                             input bit mode, input bit tracks, input int rate);
        write_reg(CFG_FIXED_RADIUS, 18'(rr_big));
        write_reg(CFG_ROTATING_RADIUS, 18'(rr_small));
        write_reg(CFG_DISTANCE, 18'(dd));
        write_reg(CFG_FREQUENCY, 18'(ff));
        write_reg(CFG_CURVE_MODE, 18'(mode));
        write_reg(CFG_DIST_TRACKS, 18'(tracks));
        write_reg(CFG_SAMPLE_RATE, 18'(rate));
    endtask

    // mostly nominal voltages, sometimes any 15-bit code
    function automatic logic signed [14:0] rand_cv();
        if ($urandom_range(0, 4) == 0)
            return 15'($urandom);
        return 15'($signed($urandom_range(0, 20480)) - 10240);
    endfunction

    // default knobs straight out of reset, plus field extremes and special cases
    task automatic test_reset_defaults();
        send_sample(0, 0, 0, 0);
        send_sample(10240, 10240, 10240, 10240);
        send_sample(-10240, -10240, -10240, -10240);
        send_sample(15'sh3FFF, 15'sh3FFF, 15'sh3FFF, 15'sh3FFF);
        send_sample(15'sh4000, 15'sh4000, 15'sh4000, 15'sh4000);
        // equal radii: fixed pulled up onto rolling
        send_sample(2048, -2048, 0, 0);
        send_sample(2048, -10240, 0, 0);
        // very low pitch, small increment
        send_sample(-10240, 0, 0, 0);
        send_sample(8192, 1000, -500, 300);
        wait_idle();
    endtask

    task automatic test_special_configs();
        // epitrochoid with d tied to r, fast phase
        write_all(20480, 1024, 10240, 4096, 1, 1, 1000);
        send_sample(10240, 10240, -10240, 0);
        send_sample(4096, -10240, 10240, 10240);
        send_sample(0, 0, 0, 0);
        wait_idle();
        // zero sample rate counts as 1 Hz; out-of-range knobs and an unused index
        write_all(32767, 16383, 16383, 8191, 0, 0, 0);
        write_reg(CFG_UNUSED_IDX, 18'h3FFFF);
        send_sample(-10240, 0, 0, 0);
        send_sample(10240, -10240, -10240, -10240);
        wait_idle();
        write_all(0, 0, 0, 18'h2000, 0, 1, 18'h3FFFF);
        send_sample(10240, 5000, 100, -100);
        send_sample(-10240, -5000, 10240, 10240);
        send_sample(10240, 0, -10240, 0);
        wait_idle();
        write_all(1024, 10240, 1024, -8192, 1, 0, 192000);
        send_sample(10240, 0, 0, 0);
        send_sample(0, -10240, 10240, -10240);
        wait_idle();
    endtask

    // random phases: register sets drawn from nominal and full code ranges
    task automatic test_random_sweep();
        for (int phase_n = 0; phase_n < 8; phase_n++)
        begin
            if (phase_n % 3 == 2)
                write_all($urandom_range(0, 32767), $urandom_range(0, 16383),
                          $urandom_range(0, 16383), $urandom_range(0, 16383),
                          $urandom_range(0, 1), $urandom_range(0, 1),
                          $urandom_range(0, 262143));
            else
                write_all($urandom_range(1024, 20480), $urandom_range(1024, 10240),
                          $urandom_range(1024, 10240), $urandom_range(0, 12288) - 8192,
                          $urandom_range(0, 1), $urandom_range(0, 3) == 0,
                          $urandom_range(1000, 192000));
            // stretches with and without idling, and with and without output stalls
            gaps_on      = phase_n != 4;
            ready_steady = phase_n == 4 || phase_n == 6;
            for (int n = 0; n < 80; n++)
                send_sample(rand_cv(), rand_cv(), rand_cv(), rand_cv());
            wait_idle();
        end
        gaps_on      = 1;
        ready_steady = 0;
    endtask

    // receiver holds off for a long stretch while samples keep coming
    task automatic test_output_backpressure();
        write_all(5120, 3072, 5120, 2048, 0, 0, 48000);
        out_hold = 1500;
        gaps_on  = 0;
        for (int n = 0; n < 30; n++)
            send_sample(rand_cv(), rand_cv(), rand_cv(), rand_cv());
        gaps_on = 1;
        wait_idle();
    endtask

    initial
    begin
        errors       = 0;
        samples_sent = 0;
        points_seen  = 0;
        cycle_count  = 0;
        out_stall    = 0;
        out_hold     = 0;
        ready_steady = 0;
        gaps_on      = 1;
        phase_acc    = 0;
        knobs        = '{fixed_radius_knob: 15'd5120, rotating_radius_knob: 14'd3072,
                         distance_knob: 14'd5120, frequency_knob: 14'sd0,
                         curve_mode: 1'b0, distance_tracks_radius: 1'b0,
                         sample_rate_hz: 18'd44100};
        exp_coef[1] = int_sqrt(64'd1 << 61);
        for (int j = 1; j < 10; j++)
            exp_coef[j + 1] = int_sqrt(exp_coef[j] << 30);

        rst_n                        = 1'b0;
        sample_ch.valid              = 1'b0;
        sample_ch.pitch_cv           = '0;
        sample_ch.fixed_radius_cv    = '0;
        sample_ch.rotating_radius_cv = '0;
        sample_ch.distance_cv        = '0;
        point_ch.ready               = 1'b0;
        cfg_ch.valid                 = 1'b0;
        cfg_ch.index                 = CFG_FIXED_RADIUS;
        cfg_ch.data                  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_special_configs();
        test_random_sweep();
        test_output_backpressure();

        // final drain with a bounded wait
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d sample transactions and %0d points across hypo/epi modes,",
                 samples_sent, points_seen);
        $display("register extremes, zero rate, long output hold; %0d mismatches", errors);
        if (errors == 0 && pending_points.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/rclfo_pkg.sv
src/rclfo_if.sv
src/rclfo_div.sv
src/rclfo_cordic.sv
src/rclfo_dp.sv
src/rclfo_ctrl.sv
src/roulette_curve_lfo_unit.sv
sim/tb.sv
